[design/tis_pkg.sv]
// shared types and constants for the trace interval statistics monitor
// no dependencies; used by tis_lane and trace_interval_statistics
package tis_pkg;

  localparam int unsigned EV_SLOTS = 6;
  localparam int unsigned STAT_W   = 64;
  localparam int unsigned READ_W   = 63;
  localparam int unsigned OP_W     = 3;
  localparam int unsigned MASK_W   = 6;
  localparam int unsigned PADDR_W  = 4;
  localparam int unsigned PDATA_W  = 32;

  typedef enum logic [OP_W-1:0] {
    OP_START      = 3'd0,
    OP_END        = 3'd1,
    OP_COUNT_CALL = 3'd2,
    OP_ADD_WEIGHT = 3'd3,
    OP_CLEAR      = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    REG_EVENT_MASK  = 2'd0,
    REG_CALL_EN     = 2'd1,
    REG_WEIGHT_EN   = 2'd2,
    REG_TIMING_EN   = 2'd3
  } reg_idx_e;

  // per-counter control for one statistics update
  typedef struct packed {
    logic update;
    logic start;
    logic finish;
    logic clear;
    logic enable;
  } lane_ctl_t;

endpackage

[design/tis_lane.sv]
// one event counter lane: start snapshot and accumulated positive delta
// depends on tis_pkg (lane_ctl_t, widths)
module tis_lane (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  tis_pkg::lane_ctl_t                 ctl_i,
  input  logic [tis_pkg::READ_W-1:0]         reading_i,
  output logic [tis_pkg::STAT_W-1:0]         accum_o
);

  logic [tis_pkg::READ_W-1:0] snap_q, snap_d;
  logic [tis_pkg::STAT_W-1:0] accum_q, accum_d;
  logic [tis_pkg::READ_W-1:0] delta;

  assign delta = reading_i - snap_q;

  always_comb begin
    snap_d  = snap_q;
    accum_d = accum_q;
    if (ctl_i.clear) begin
      snap_d  = '0;
      accum_d = '0;
    end else if (ctl_i.start && ctl_i.enable) begin
      snap_d = reading_i;
    end else if (ctl_i.finish && ctl_i.enable && (reading_i > snap_q)) begin
      accum_d = accum_q + {1'b0, delta};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      snap_q  <= '0;
      accum_q <= '0;
    end else if (ctl_i.update) begin
      snap_q  <= snap_d;
      accum_q <= accum_d;
    end
  end

  // value after this update, for the result register
  assign accum_o = accum_d;

`ifndef ASSERT_OFF
  a_clear_zeroes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_i.update && ctl_i.clear) |=> (accum_q == '0 && snap_q == '0))
    else $error("lane not cleared");
  a_no_change_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ctl_i.update |=> ($stable(accum_q) && $stable(snap_q)))
    else $error("lane changed without update");
  a_disabled_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_i.update && !ctl_i.enable && !ctl_i.clear) |=> $stable(accum_q))
    else $error("disabled lane accumulated");
`endif

endmodule

[design/trace_interval_statistics.sv]
// an input transfer is held in the input register, and its result in the result register
// throughput: one item per cycle while the output is not stalled; updates are parallel 64/63-bit add/subtract/compare
// the input register stalls only while a result waits in the output register
// reset clears configuration, all statistics and the open interval flag
// top level of the trace interval statistics monitor; depends on tis_pkg and tis_lane
module trace_interval_statistics #(
  parameter int unsigned NUM_EVENTS = 6
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [tis_pkg::PADDR_W-1:0]        paddr,
  input  logic [tis_pkg::PDATA_W-1:0]        pwdata,
  output logic [tis_pkg::PDATA_W-1:0]        prdata,
  output logic                               pready,
  // input channel
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [tis_pkg::OP_W-1:0]           opcode_i,
  input  logic [tis_pkg::STAT_W-1:0]         timestamp_us_i,
  input  logic [tis_pkg::STAT_W-1:0]         weight_i,
  input  logic [tis_pkg::READ_W-1:0]         cycles_reading_i,
  input  logic [tis_pkg::READ_W-1:0]         instr_reading_i,
  input  logic [tis_pkg::READ_W-1:0]         cache_ref_reading_i,
  input  logic [tis_pkg::READ_W-1:0]         cache_miss_reading_i,
  input  logic [tis_pkg::READ_W-1:0]         branch_reading_i,
  input  logic [tis_pkg::READ_W-1:0]         branch_miss_reading_i,
  // output channel
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [tis_pkg::STAT_W-1:0]         cycles_total_o,
  output logic [tis_pkg::STAT_W-1:0]         instr_total_o,
  output logic [tis_pkg::STAT_W-1:0]         cache_ref_total_o,
  output logic [tis_pkg::STAT_W-1:0]         cache_miss_total_o,
  output logic [tis_pkg::STAT_W-1:0]         branch_total_o,
  output logic [tis_pkg::STAT_W-1:0]         branch_miss_total_o,
  output logic [tis_pkg::STAT_W-1:0]         call_count_out_o,
  output logic [tis_pkg::STAT_W-1:0]         weighted_count_out_o,
  output logic [tis_pkg::STAT_W-1:0]         total_time_out_o,
  output logic [tis_pkg::STAT_W-1:0]         max_time_out_o,
  output logic [tis_pkg::STAT_W-1:0]         min_time_out_o,
  output logic                               interval_open_o
);

  localparam int unsigned EV = tis_pkg::EV_SLOTS;
  localparam int unsigned SW = tis_pkg::STAT_W;

  // ---------------- configuration registers ----------------
  logic [tis_pkg::MASK_W-1:0] ev_mask_q;
  logic                       call_en_q, weight_en_q, timing_en_q;
  logic                       cfg_wr;
  tis_pkg::reg_idx_e          cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = tis_pkg::reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ev_mask_q   <= '0;
      call_en_q   <= 1'b0;
      weight_en_q <= 1'b0;
      timing_en_q <= 1'b0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        tis_pkg::REG_EVENT_MASK: ev_mask_q   <= pwdata[tis_pkg::MASK_W-1:0];
        tis_pkg::REG_CALL_EN:    call_en_q   <= pwdata[0];
        tis_pkg::REG_WEIGHT_EN:  weight_en_q <= pwdata[0];
        tis_pkg::REG_TIMING_EN:  timing_en_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      tis_pkg::REG_EVENT_MASK:
        prdata = {{(tis_pkg::PDATA_W-tis_pkg::MASK_W){1'b0}}, ev_mask_q};
      tis_pkg::REG_CALL_EN:   prdata = {{(tis_pkg::PDATA_W-1){1'b0}}, call_en_q};
      tis_pkg::REG_WEIGHT_EN: prdata = {{(tis_pkg::PDATA_W-1){1'b0}}, weight_en_q};
      tis_pkg::REG_TIMING_EN: prdata = {{(tis_pkg::PDATA_W-1){1'b0}}, timing_en_q};
      default:                prdata = '0;
    endcase
  end

  // ---------------- input register ----------------
  logic                        s1_valid_q;
  logic [tis_pkg::OP_W-1:0]    s1_op_q;
  logic [SW-1:0]               s1_ts_q, s1_weight_q;
  logic [tis_pkg::READ_W-1:0]  s1_rd_q [EV];
  logic                        out_valid_q;
  logic                        adv;
  logic                        in_xfer;

  // item moves from the input register into the result register
  assign adv        = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !adv;
  assign in_xfer    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_q <= 1'b1;
    end else if (adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_op_q     <= opcode_i;
      s1_ts_q     <= timestamp_us_i;
      s1_weight_q <= weight_i;
      s1_rd_q[0]  <= cycles_reading_i;
      s1_rd_q[1]  <= instr_reading_i;
      s1_rd_q[2]  <= cache_ref_reading_i;
      s1_rd_q[3]  <= cache_miss_reading_i;
      s1_rd_q[4]  <= branch_reading_i;
      s1_rd_q[5]  <= branch_miss_reading_i;
    end
  end

  // ---------------- statistics update ----------------
  logic          open_q, open_d;
  logic [SW-1:0] call_q, call_d;
  logic [SW-1:0] wsum_q, wsum_d;
  logic [SW-1:0] start_q, start_d;
  logic [SW-1:0] tsum_q, tsum_d;
  logic [SW-1:0] tmax_q, tmax_d;
  logic [SW-1:0] tmin_q, tmin_d;
  logic [SW-1:0] dur, w_room;
  logic          start_fire, end_fire, clr;

  assign start_fire = (s1_op_q == tis_pkg::OP_START) && !open_q;
  assign end_fire   = (s1_op_q == tis_pkg::OP_END) && open_q;
  assign clr        = (s1_op_q == tis_pkg::OP_CLEAR);
  assign dur        = s1_ts_q - start_q;
  assign w_room     = {SW{1'b1}} - wsum_q;

  always_comb begin
    open_d  = open_q;
    call_d  = call_q;
    wsum_d  = wsum_q;
    start_d = start_q;
    tsum_d  = tsum_q;
    tmax_d  = tmax_q;
    tmin_d  = tmin_q;
    unique case (tis_pkg::op_e'(s1_op_q))
      tis_pkg::OP_START: begin
        if (start_fire) begin
          open_d = 1'b1;
          if (call_en_q) call_d = call_q + SW'(1);
          if (timing_en_q) start_d = s1_ts_q;
        end
      end
      tis_pkg::OP_END: begin
        if (end_fire) begin
          open_d = 1'b0;
          if (timing_en_q) begin
            tsum_d  = tsum_q + dur;
            start_d = '0;
            if ((tmax_q == '0) || (dur > tmax_q)) tmax_d = dur;
            if ((tmin_q == '0) || (tmin_q > dur)) tmin_d = dur;
          end
        end
      end
      tis_pkg::OP_COUNT_CALL: begin
        if (call_en_q) call_d = call_q + SW'(1);
      end
      tis_pkg::OP_ADD_WEIGHT: begin
        if (weight_en_q) begin
          // saturate at all ones
          wsum_d = (s1_weight_q >= w_room) ? {SW{1'b1}} : (wsum_q + s1_weight_q);
        end
      end
      tis_pkg::OP_CLEAR: begin
        open_d  = 1'b0;
        call_d  = '0;
        wsum_d  = '0;
        start_d = '0;
        tsum_d  = '0;
        tmax_d  = '0;
        tmin_d  = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q  <= 1'b0;
      call_q  <= '0;
      wsum_q  <= '0;
      start_q <= '0;
      tsum_q  <= '0;
      tmax_q  <= '0;
      tmin_q  <= '0;
    end else if (adv) begin
      open_q  <= open_d;
      call_q  <= call_d;
      wsum_q  <= wsum_d;
      start_q <= start_d;
      tsum_q  <= tsum_d;
      tmax_q  <= tmax_d;
      tmin_q  <= tmin_d;
    end
  end

  // ---------------- event counter lanes ----------------
  logic [SW-1:0] lane_accum [EV];
  logic [SW-1:0] lane_out   [EV];

  for (genvar i = 0; i < EV; i++) begin : g_lane
    tis_pkg::lane_ctl_t ctl;
    logic               lane_en;

    assign lane_en    = (i < NUM_EVENTS) && ev_mask_q[i];
    assign ctl.update = adv;
    assign ctl.start  = start_fire;
    assign ctl.finish = end_fire;
    assign ctl.clear  = clr;
    assign ctl.enable = lane_en;

    tis_lane u_lane (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctl_i     (ctl),
      .reading_i (s1_rd_q[i]),
      .accum_o   (lane_accum[i])
    );

    assign lane_out[i] = lane_en ? lane_accum[i] : '0;
  end

  // ---------------- result register ----------------
  logic [SW-1:0] res_ev_q [EV];
  logic [SW-1:0] res_call_q, res_w_q, res_tsum_q, res_tmax_q, res_tmin_q;
  logic          res_open_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < EV; k++) begin
        res_ev_q[k] <= lane_out[k];
      end
      res_call_q <= call_en_q ? call_d : '0;
      res_w_q    <= weight_en_q ? wsum_d : '0;
      res_tsum_q <= timing_en_q ? tsum_d : '0;
      res_tmax_q <= timing_en_q ? tmax_d : '0;
      res_tmin_q <= timing_en_q ? tmin_d : '0;
      res_open_q <= open_d;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign cycles_total_o       = res_ev_q[0];
  assign instr_total_o        = res_ev_q[1];
  assign cache_ref_total_o    = res_ev_q[2];
  assign cache_miss_total_o   = res_ev_q[3];
  assign branch_total_o       = res_ev_q[4];
  assign branch_miss_total_o  = res_ev_q[5];
  assign call_count_out_o     = res_call_q;
  assign weighted_count_out_o = res_w_q;
  assign total_time_out_o     = res_tsum_q;
  assign max_time_out_o       = res_tmax_q;
  assign min_time_out_o       = res_tmin_q;
  assign interval_open_o      = res_open_q;

`ifndef ASSERT_OFF
  a_start_opens: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && s1_op_q == tis_pkg::OP_START) |=> open_q)
    else $error("start did not leave an interval open");
  a_clear_zeroes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && s1_op_q == tis_pkg::OP_CLEAR) |=>
      (!open_q && wsum_q == '0 && tsum_q == '0 && call_q == '0))
    else $error("clear left statistics behind");
  a_min_le_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tmin_q <= tmax_q)
    else $error("minimum duration above maximum");
  a_result_follows_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> (out_valid_q && res_open_q == open_q))
    else $error("result register out of step with state");
`endif

endmodule
